// ----- hw/rtl/sgr_pkg.sv -----
`timescale 1ns / 1ps

package sgr_pkg;

  // Field widths.
  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 18;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 18;

  // Default parameter values.
  localparam int SINE_TABLE_SIZE_DEF = 256;
  localparam int RAMP_STEP_DEF       = 66;

  // Fixed-point units.
  localparam int ONE_Q15 = 32768;
  localparam int ONE_Q12 = 4096;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  // Reset values of the configuration registers and the gain.
  localparam logic [POS_W-1:0]  POT_RESET       = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_HIGH_RESET = 18'd65536;
  localparam logic [GAIN_W-1:0] GAIN_UNITY      = 18'd65536;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POT       = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_LOW  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_HIGH = 4'd3;

  // One quarter-wave table entry: sin(angle) with angle in Q30, rounded to Q15.
  // Evaluated at elaboration only, as a nine-term Taylor series with
  // divisions that truncate toward zero.
  function automatic logic [15:0] sine_entry(input longint angle);
    longint term;
    longint sum;
    term = angle;
    sum  = angle;
    for (int k = 1; k <= 8; k++) begin
      term = (term * angle) / 1073741824;
      term = (term * angle) / 1073741824;
      case (k)
        1:       term = -term / 6;
        2:       term = -term / 20;
        3:       term = -term / 42;
        4:       term = -term / 72;
        5:       term = -term / 110;
        6:       term = -term / 156;
        7:       term = -term / 210;
        default: term = -term / 272;
      endcase
      sum = sum + term;
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 1073741824) begin
      sum = 1073741824;
    end
    return 16'((sum + 16384) / 32768);
  endfunction

endpackage

// ----- hw/rtl/shaped_gain_ramp.sv -----
`timescale 1ns / 1ps

// Shaped, smoothed volume control for signed 24-bit audio.
// Configuration comes in on the cfg channel (index, data): pot position,
// taper shape, and the gains at pot zero and pot full. The channel is ready
// whenever the block is idle; any write to a known register marks the target
// gain stale. While a write is offered, s_axis_tready stays low so that a
// write and a sample never land on the same edge. Samples arrive as stream
// beats on s_axis; each sample gives one beat on m_axis carrying the scaled,
// saturated sample and the gain applied.
// With a current target, an accepted sample takes one ramp step, one pass
// through the shared multiplier and the load of the output register; the
// block then returns to idle, where it accepts the next sample.
// The first sample after reset or a write to a known register also
// recomputes the target: one curve application for every whole shape unit
// beyond one and one for the final blended curve, then the blend and the
// gain mapping, before the ramp step.
// All products go through one 25x19 multiplier with a registered result.
// Reset sets unity gain, the register defaults, a stale target and an empty
// output register. When the receiver stalls, the finished beat waits in the
// output register; the next sample is still accepted and worked on, and the
// block only waits before its own output load until the register drains.
module shaped_gain_ramp #(
  parameter int SINE_TABLE_SIZE = sgr_pkg::SINE_TABLE_SIZE_DEF,
  parameter int RAMP_STEP       = sgr_pkg::RAMP_STEP_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sgr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sgr_pkg::CFG_DAT_W-1:0] cfg_data_i,
  // Sample input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // [23:0] sample_in
  // Sample output.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata   // [23:0] sample_out,
                                                       // [41:24] gain_now,
                                                       // [47:42] zero
);
  import sgr_pkg::*;

  localparam int AddrW = $clog2(SINE_TABLE_SIZE + 1);
  localparam logic [AddrW-1:0]  TopAddr  = AddrW'(SINE_TABLE_SIZE);
  localparam logic [18:0]       Step     = 19'(RAMP_STEP);
  localparam logic signed [16:0] ShapeOne = 17'(ONE_Q12);
  localparam logic [15:0]       PosOne   = 16'(ONE_Q15);
  localparam logic [12:0]       WgtOne   = 13'(ONE_Q12);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_SQ, ST_SK, ST_SROM, ST_SDIFF, ST_SSUM,
    ST_B1, ST_B2, ST_B3, ST_M1, ST_M2, ST_M3, ST_RAMP, ST_SMUL, ST_OUT
  } state_e;

  // Quarter-wave sine table, entries 0..SINE_TABLE_SIZE, built at elaboration.
  logic [15:0] sine_rom [SINE_TABLE_SIZE+1];
  for (genvar g = 0; g <= SINE_TABLE_SIZE; g++) begin : g_rom
    localparam longint Angle = (HALF_PI_Q30 * longint'(g)) / longint'(SINE_TABLE_SIZE);
    assign sine_rom[g] = sine_entry(Angle);
  end

  state_e state_q;

  // Configuration registers and ramp state.
  logic [POS_W-1:0]        pot_q;
  logic signed [POS_W-1:0] shape_q;
  logic [GAIN_W-1:0]       gain_low_q;
  logic [GAIN_W-1:0]       gain_high_q;
  logic [GAIN_W-1:0]       gain_level_q;
  logic [GAIN_W-1:0]       target_q;
  logic                    target_fresh_q;

  // Working registers of the target computation.
  logic [15:0]        x_q;
  logic signed [16:0] r_q;
  logic [12:0]        w_q;
  logic               op_sin_q;
  logic               whole_q;
  logic [15:0]        arg_q;
  logic [AddrW-1:0]   addr_q;
  logic [14:0]        f_q;
  logic [15:0]        e0_q;
  logic [15:0]        e1_q;
  logic [15:0]        c_q;
  logic [15:0]        p_q;
  logic [43:0]        acc_q;
  logic signed [SAMPLE_W-1:0] sample_q;

  // Shared multiplier.
  logic signed [24:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [43:0] prod_q;

  // Output register.
  logic        out_valid_q;
  logic [47:0] out_data_q;

  logic in_accept;
  logic cfg_write;
  logic cfg_known;
  logic out_load;

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_write     = cfg_valid_i && cfg_ready_o;
  assign cfg_known     = (cfg_index_i == REG_POT) || (cfg_index_i == REG_SHAPE) ||
                         (cfg_index_i == REG_GAIN_LOW) || (cfg_index_i == REG_GAIN_HIGH);
  // The finished beat loads once the output register is empty or draining.
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Datapath helpers.
  logic [15:0] e1_max;
  logic [30:0] sine_rnd;
  logic [15:0] sine_val;
  logic [15:0] curve_val;
  logic [44:0] acc_sum;
  logic [16:0] blend_p;
  logic [AddrW-1:0] k_idx;
  logic [AddrW-1:0] addr_next;
  logic [44:0] y_sum;
  logic signed [28:0] y_full;
  logic [23:0] y_sat;
  logic [18:0] gain_up;
  logic [18:0] gain_dn;
  logic [GAIN_W-1:0] gain_d;

  assign e1_max    = (e1_q < e0_q) ? e0_q : e1_q;
  assign sine_rnd  = prod_q[30:0] + 31'd16384;
  assign sine_val  = e0_q + sine_rnd[30:15];
  assign curve_val = op_sin_q ? sine_val : PosOne - sine_val;
  assign acc_sum   = {1'b0, acc_q} + {1'b0, prod_q};
  assign blend_p   = 17'((acc_sum + 45'd2048) >> 12);
  assign k_idx     = prod_q[15 +: AddrW];
  assign addr_next = (addr_q == TopAddr) ? addr_q : addr_q + 1'b1;
  assign y_sum     = 45'(prod_q) + 45'sd32768;
  assign y_full    = $signed(y_sum[44:16]);

  always_comb begin
    if (y_full > 29'sd8388607) begin
      y_sat = 24'h7FFFFF;
    end else if (y_full < -29'sd8388608) begin
      y_sat = 24'h800000;
    end else begin
      y_sat = y_full[23:0];
    end
  end

  // One ramp step toward the target, landing on it when within a step.
  assign gain_up = 19'(target_q) - 19'(gain_level_q);
  assign gain_dn = 19'(gain_level_q) - 19'(target_q);
  always_comb begin
    if (gain_level_q > target_q) begin
      gain_d = (gain_dn <= Step) ? target_q : GAIN_W'(19'(gain_level_q) - Step);
    end else if (gain_level_q < target_q) begin
      gain_d = (gain_up <= Step) ? target_q : GAIN_W'(19'(gain_level_q) + Step);
    end else begin
      gain_d = gain_level_q;
    end
  end

  // Operand selection for the shared multiplier. The sample product is held
  // through the output state so that it survives a stalled output load.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        mul_a = 25'(arg_q);
        mul_b = 19'(SINE_TABLE_SIZE);
      end
      ST_SDIFF: begin
        mul_a = 25'(e1_max - e0_q);
        mul_b = 19'(f_q);
      end
      ST_B1: begin
        mul_a = 25'(x_q);
        mul_b = 19'(WgtOne - w_q);
      end
      ST_B2: begin
        mul_a = 25'(c_q);
        mul_b = 19'(w_q);
      end
      ST_M1: begin
        mul_a = 25'(gain_low_q);
        mul_b = 19'(PosOne - p_q);
      end
      ST_M2: begin
        mul_a = 25'(gain_high_q);
        mul_b = 19'(p_q);
      end
      ST_SMUL, ST_OUT: begin
        mul_a = 25'(sample_q);
        mul_b = 19'(gain_level_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      pot_q          <= POT_RESET;
      shape_q        <= '0;
      gain_low_q     <= '0;
      gain_high_q    <= GAIN_HIGH_RESET;
      gain_level_q   <= GAIN_UNITY;
      target_q       <= '0;
      target_fresh_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      prod_q <= 44'(mul_a) * 44'(mul_b);
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {6'b0, gain_level_q, y_sat};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index_i)
          REG_POT:       pot_q       <= cfg_data_i[15:0];
          REG_SHAPE:     shape_q     <= $signed(cfg_data_i[15:0]);
          REG_GAIN_LOW:  gain_low_q  <= cfg_data_i;
          REG_GAIN_HIGH: gain_high_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_known) begin
          target_fresh_q <= 1'b0;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            sample_q <= $signed(s_axis_tdata);
            x_q      <= (pot_q > PosOne) ? PosOne : pot_q;
            r_q      <= 17'(shape_q);
            if (target_fresh_q && !(cfg_write && cfg_known)) begin
              state_q <= ST_RAMP;
            end else begin
              state_q <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (r_q > ShapeOne) begin
            op_sin_q <= 1'b1;
            whole_q  <= 1'b1;
            r_q      <= r_q - ShapeOne;
            arg_q    <= x_q;
          end else if (r_q < -ShapeOne) begin
            op_sin_q <= 1'b0;
            whole_q  <= 1'b1;
            r_q      <= r_q + ShapeOne;
            arg_q    <= PosOne - x_q;
          end else begin
            op_sin_q <= (r_q >= 0);
            whole_q  <= 1'b0;
            w_q      <= (r_q >= 0) ? 13'(r_q) : 13'(-r_q);
            arg_q    <= (r_q >= 0) ? x_q : PosOne - x_q;
          end
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          state_q <= ST_SK;
        end
        ST_SK: begin
          // Table position is the integer part, the Q15 remainder interpolates.
          if (k_idx >= TopAddr) begin
            addr_q <= TopAddr;
            f_q    <= '0;
          end else begin
            addr_q <= k_idx;
            f_q    <= prod_q[14:0];
          end
          state_q <= ST_SROM;
        end
        ST_SROM: begin
          e0_q    <= sine_rom[addr_q];
          e1_q    <= sine_rom[addr_next];
          state_q <= ST_SDIFF;
        end
        ST_SDIFF: begin
          state_q <= ST_SSUM;
        end
        ST_SSUM: begin
          if (whole_q) begin
            x_q     <= curve_val;
            state_q <= ST_DECIDE;
          end else begin
            c_q     <= curve_val;
            state_q <= ST_B1;
          end
        end
        ST_B1: begin
          state_q <= ST_B2;
        end
        ST_B2: begin
          acc_q   <= prod_q;
          state_q <= ST_B3;
        end
        ST_B3: begin
          p_q     <= (blend_p > 17'(PosOne)) ? PosOne : blend_p[15:0];
          state_q <= ST_M1;
        end
        ST_M1: begin
          state_q <= ST_M2;
        end
        ST_M2: begin
          acc_q   <= prod_q;
          state_q <= ST_M3;
        end
        ST_M3: begin
          target_q       <= GAIN_W'((acc_sum + 45'd16384) >> 15);
          target_fresh_q <= 1'b1;
          state_q        <= ST_RAMP;
        end
        ST_RAMP: begin
          gain_level_q <= gain_d;
          state_q      <= ST_SMUL;
        end
        ST_SMUL: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // A known register write always leaves the target stale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_write && cfg_known) |=> !target_fresh_q)
    else $error("target still marked fresh after a register write");

  // The target computation ends with a fresh target.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_M3) |=> (target_fresh_q && state_q == ST_RAMP))
    else $error("target computation did not mark the target fresh");

  // A ramp step lands on the target or moves exactly one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RAMP) |=>
      ((gain_level_q == target_q) ||
       (19'(gain_level_q) == 19'($past(gain_level_q)) + Step) ||
       (19'(gain_level_q) + Step == 19'($past(gain_level_q)))))
    else $error("gain ramp moved by other than one step");

  // The table address never runs past the last entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SROM) |-> (addr_q <= TopAddr))
    else $error("sine table address out of range");

  // The output load never overwrites a beat that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("waiting output beat was overwritten");

endmodule
